FILE: rtl/sidc_pkg.sv
// ----------------------------------------------------------------------------
// sidc_pkg
// Shared types and constants of the idle offset and dead zone calibrator:
// field widths, stream packing, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sidc_pkg;

	// Sensor lanes and sample format.
	localparam int MAX_SENSORS = 8;
	localparam int SAMPLE_BITS = 10;
	localparam int IDX_W       = 3;
	localparam int ROUND_W     = 16;
	localparam int SUM_W       = SAMPLE_BITS + ROUND_W;
	localparam int DZ_W        = SAMPLE_BITS + 1;
	localparam int DIFF_W      = SAMPLE_BITS + 2;
	localparam int CNT_W       = $clog2(SAMPLE_BITS);
	localparam int MARGIN      = 2;

	// Reset values of the per-sensor stores.
	localparam logic [SAMPLE_BITS-1:0] LOW_INIT = {SAMPLE_BITS{1'b1}};

	// Input stream packing: mask in the low byte, then one sample per sensor.
	localparam int MASK_W     = 8;
	localparam int S_DATA_W   = MASK_W + MAX_SENSORS * SAMPLE_BITS;

	// Output stream packing, lowest field first.
	localparam int O_IDX_LSB  = 0;
	localparam int O_IDLE_LSB = O_IDX_LSB + IDX_W;
	localparam int O_MIN_LSB  = O_IDLE_LSB + SAMPLE_BITS;
	localparam int O_MAX_LSB  = O_MIN_LSB + SAMPLE_BITS;
	localparam int O_DZ_LSB   = O_MAX_LSB + SAMPLE_BITS;
	localparam int O_POS_BIT  = O_DZ_LSB + DZ_W;
	localparam int O_ZONE_BIT = O_POS_BIT + 1;
	localparam int O_PEAK_LSB = O_ZONE_BIT + 1;
	localparam int O_ANY_BIT  = O_PEAK_LSB + DZ_W;
	localparam int O_USED_W   = O_ANY_BIT + 1;
	localparam int M_DATA_W   = ((O_USED_W + 7) / 8) * 8;

	// Configuration register map.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_REQ_ITER = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DZ_LIMIT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WIN_LO   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_WIN_HI   = 2'd3;

	localparam logic [ROUND_W-1:0]     REQ_ITER_RST = 16'd100;
	localparam logic [SAMPLE_BITS-1:0] DZ_LIMIT_RST = 10'd10;
	localparam logic [SAMPLE_BITS-1:0] WIN_LO_RST   = 10'd0;
	localparam logic [SAMPLE_BITS-1:0] WIN_HI_RST   = 10'd1023;

	typedef struct packed {
		logic [ROUND_W-1:0]     req_iter;
		logic [SAMPLE_BITS-1:0] dz_limit;
		logic [SAMPLE_BITS-1:0] win_lo;
		logic [SAMPLE_BITS-1:0] win_hi;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_EVAL,
		ST_EMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;   // finish begins at sensor 0
		logic accum;   // add one reading round
		logic clear;   // restart calibration
		logic load;    // set up divider for current sensor
		logic step;    // one quotient bit
		logic eval;    // dead zone and window check
		logic emit;    // write result into output register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic finish_due;
		logic rounds_zero;
		logic div_done;
		logic last_sensor;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/sensor_idle_deadzone_calibrator_core.sv
// ----------------------------------------------------------------------------
// sensor_idle_deadzone_calibrator_core
// Idle offset and dead zone calibration for up to eight sensors: reading
// rounds accumulate, a finish round reports mean, extremes and warnings.
// ----------------------------------------------------------------------------
// Reading rounds may follow every cycle while the controller is idle. A
// finish round stalls the input and, for each sensor, runs a load, 10
// divide steps for the mean, evaluation and hand-off, the hand-off waiting
// while the output stalls; the bit-serial divider does the divide steps.
// The first result is registered after sensor 0 has been evaluated.
// Reset restores the register defaults and clears all calibration state.
module sensor_idle_deadzone_calibrator_core #(
	parameter int NUM_SENSORS = sidc_pkg::MAX_SENSORS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes.
	input  logic                            cfg_we,
	input  logic [sidc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sidc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Reading rounds.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// present_mask, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5, raw_6, raw_7
	input  logic [sidc_pkg::S_DATA_W-1:0]   s_tdata,
	// Per-sensor results.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// sensor_index, idle_position, min_reading, max_reading, dead_zone,
	// position_warning, zone_warning, largest_dead_zone, any_warning, zero fill
	output logic [sidc_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast
);

	sidc_pkg::cfg_t    cfg_q;
	sidc_pkg::cmd_t    cmd;
	sidc_pkg::status_t status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.req_iter <= sidc_pkg::REQ_ITER_RST;
			cfg_q.dz_limit <= sidc_pkg::DZ_LIMIT_RST;
			cfg_q.win_lo   <= sidc_pkg::WIN_LO_RST;
			cfg_q.win_hi   <= sidc_pkg::WIN_HI_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				sidc_pkg::REG_REQ_ITER: cfg_q.req_iter <= cfg_wdata;
				sidc_pkg::REG_DZ_LIMIT: cfg_q.dz_limit <= cfg_wdata[sidc_pkg::SAMPLE_BITS-1:0];
				sidc_pkg::REG_WIN_LO:   cfg_q.win_lo   <= cfg_wdata[sidc_pkg::SAMPLE_BITS-1:0];
				sidc_pkg::REG_WIN_HI:   cfg_q.win_hi   <= cfg_wdata[sidc_pkg::SAMPLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	sidc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sidc_datapath #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

FILE: rtl/sidc_ctrl.sv
// ----------------------------------------------------------------------------
// sidc_ctrl
// Controller of the calibrator: takes reading rounds, and on a finish round
// sequences divide, evaluation and result hand-off for each sensor.
// ----------------------------------------------------------------------------
module sidc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sidc_pkg::status_t status,
	output sidc_pkg::cmd_t    cmd
);

	sidc_pkg::state_t state_q, state_d;
	logic             accept;

	assign in_ready = (state_q == sidc_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sidc_pkg::ST_IDLE: begin
				if (accept && status.finish_due && !status.rounds_zero) begin
					state_d = sidc_pkg::ST_LOAD;
				end
			end
			sidc_pkg::ST_LOAD: begin
				state_d = sidc_pkg::ST_DIV;
			end
			sidc_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_d = sidc_pkg::ST_EVAL;
				end
			end
			sidc_pkg::ST_EVAL: begin
				state_d = sidc_pkg::ST_EMIT;
			end
			sidc_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_d = status.last_sensor ? sidc_pkg::ST_IDLE : sidc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = sidc_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			sidc_pkg::ST_IDLE: begin
				if (accept) begin
					if (!status.finish_due) begin
						cmd.accum = 1'b1;
					end else if (status.rounds_zero) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.start = 1'b1;
					end
				end
			end
			sidc_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
			end
			sidc_pkg::ST_DIV: begin
				cmd.step = 1'b1;
			end
			sidc_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			sidc_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					cmd.clear = status.last_sensor;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/sidc_datapath.sv
// ----------------------------------------------------------------------------
// sidc_datapath
// Per-sensor sum, minimum and maximum stores, the round counter, a bit-serial
// restoring divider for the mean, the dead zone evaluation and the output
// register of the result stream.
// ----------------------------------------------------------------------------
module sidc_datapath #(
	parameter int NUM_SENSORS = sidc_pkg::MAX_SENSORS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sidc_pkg::cfg_t                cfg,
	input  sidc_pkg::cmd_t                cmd,
	output sidc_pkg::status_t             status,
	input  logic [sidc_pkg::S_DATA_W-1:0] in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sidc_pkg::M_DATA_W-1:0] out_data,
	output logic                          out_last
);

	localparam int SB = sidc_pkg::SAMPLE_BITS;

	// Calibration state.
	logic [sidc_pkg::SUM_W-1:0]   sum_q  [sidc_pkg::MAX_SENSORS];
	logic [SB-1:0]                low_q  [sidc_pkg::MAX_SENSORS];
	logic [SB-1:0]                high_q [sidc_pkg::MAX_SENSORS];
	logic [sidc_pkg::ROUND_W-1:0] rounds_q;
	logic [sidc_pkg::DZ_W-1:0]    peak_q;
	logic                         warn_q;

	// Finish sequencing and divider.
	logic [sidc_pkg::IDX_W-1:0]   idx_q;
	logic [sidc_pkg::SUM_W-1:0]   rem_q;
	logic [sidc_pkg::SUM_W-1:0]   dvs_q;
	logic [SB-1:0]                quot_q;
	logic [sidc_pkg::CNT_W-1:0]   cnt_q;
	logic [sidc_pkg::DZ_W-1:0]    dz_q;
	logic                         pos_q;

	// Output register.
	logic                          out_valid_q;
	logic [sidc_pkg::M_DATA_W-1:0] out_data_q;
	logic                          out_last_q;

	logic [sidc_pkg::MASK_W-1:0]  mask;
	logic [SB-1:0]                raw [sidc_pkg::MAX_SENSORS];
	logic                         rem_ge;
	logic signed [sidc_pkg::DIFF_W-1:0] low_dz, high_dz, dz_sel;
	logic                         zone_warn;
	logic [sidc_pkg::DZ_W-1:0]    peak_new;
	logic                         warn_new;

	// Unpack the reading round.
	assign mask = in_data[sidc_pkg::MASK_W-1:0];
	always_comb begin
		for (int i = 0; i < sidc_pkg::MAX_SENSORS; i++) begin
			raw[i] = in_data[sidc_pkg::MASK_W + i*SB +: SB];
		end
	end

	// Status toward the controller.
	assign status.finish_due  = (rounds_q >= cfg.req_iter);
	assign status.rounds_zero = (rounds_q == '0);
	assign status.div_done    = (cnt_q == '0);
	assign status.last_sensor = (idx_q == sidc_pkg::IDX_W'(NUM_SENSORS - 1));
	assign status.out_free    = !out_valid_q || out_ready;

	// Accumulation stores and finish-wide peak and warning.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sidc_pkg::MAX_SENSORS; i++) begin
				sum_q[i]  <= '0;
				low_q[i]  <= sidc_pkg::LOW_INIT;
				high_q[i] <= '0;
			end
			rounds_q <= '0;
			peak_q   <= '0;
			warn_q   <= 1'b0;
		end else if (cmd.clear) begin
			for (int i = 0; i < sidc_pkg::MAX_SENSORS; i++) begin
				sum_q[i]  <= '0;
				low_q[i]  <= sidc_pkg::LOW_INIT;
				high_q[i] <= '0;
			end
			rounds_q <= '0;
			peak_q   <= '0;
			warn_q   <= 1'b0;
		end else begin
			if (cmd.accum) begin
				for (int i = 0; i < sidc_pkg::MAX_SENSORS; i++) begin
					if (i < NUM_SENSORS && mask[i]) begin
						sum_q[i] <= sum_q[i] + sidc_pkg::SUM_W'(raw[i]);
						if (raw[i] < low_q[i]) begin
							low_q[i] <= raw[i];
						end
						if (raw[i] > high_q[i]) begin
							high_q[i] <= raw[i];
						end
					end
				end
				rounds_q <= rounds_q + 1'b1;
			end
			if (cmd.emit) begin
				peak_q <= peak_new;
				warn_q <= warn_new;
			end
		end
	end

	// Sensor index of the finish sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
		end else if (cmd.emit && !status.last_sensor) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Restoring divider, one quotient bit a cycle. The mean never exceeds
	// the largest sample, so SAMPLE_BITS quotient bits cover it.
	assign rem_ge = (rem_q >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= sidc_pkg::CNT_W'(SB - 1);
		end else if (cmd.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= sum_q[idx_q];
			dvs_q  <= sidc_pkg::SUM_W'(rounds_q) << (SB - 1);
			quot_q <= '0;
		end else if (cmd.step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quot_q <= {quot_q[SB-2:0], rem_ge};
			dvs_q  <= dvs_q >> 1;
		end
	end

	// Dead zone and idle window check on the finished mean.
	assign low_dz  = $signed({2'b00, quot_q}) - $signed({2'b00, low_q[idx_q]});
	assign high_dz = $signed({2'b00, high_q[idx_q]}) - $signed({2'b00, quot_q});
	assign dz_sel  = ((low_dz > high_dz) ? low_dz : high_dz)
		+ sidc_pkg::DIFF_W'(sidc_pkg::MARGIN);

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			dz_q  <= dz_sel[sidc_pkg::DZ_W-1:0];
			pos_q <= (quot_q < cfg.win_lo) || (quot_q > cfg.win_hi);
		end
	end

	// Limit check and running peak and warning for the result.
	assign zone_warn = (dz_q > sidc_pkg::DZ_W'(cfg.dz_limit));
	assign peak_new  = (dz_q > peak_q) ? dz_q : peak_q;
	assign warn_new  = warn_q || pos_q || zone_warn;

	// Output register: a result waits here while the next round is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q[sidc_pkg::M_DATA_W-1:sidc_pkg::O_USED_W] <= '0;
			out_data_q[sidc_pkg::O_IDX_LSB  +: sidc_pkg::IDX_W] <= idx_q;
			out_data_q[sidc_pkg::O_IDLE_LSB +: SB]              <= quot_q;
			out_data_q[sidc_pkg::O_MIN_LSB  +: SB]              <= low_q[idx_q];
			out_data_q[sidc_pkg::O_MAX_LSB  +: SB]              <= high_q[idx_q];
			out_data_q[sidc_pkg::O_DZ_LSB   +: sidc_pkg::DZ_W]  <= dz_q;
			out_data_q[sidc_pkg::O_POS_BIT]                     <= pos_q;
			out_data_q[sidc_pkg::O_ZONE_BIT]                    <= zone_warn;
			out_data_q[sidc_pkg::O_PEAK_LSB +: sidc_pkg::DZ_W]  <= peak_new;
			out_data_q[sidc_pkg::O_ANY_BIT]                     <= warn_new;
			out_last_q <= status.last_sensor;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

FILE: tb/calib_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calib_result_checker
// Follows the register writes and both streams of the calibrator. It keeps
// its own copy of the calibration state and predicts the per-sensor reports
// of each finish round. It also compares every result transfer with the
// oldest report that is still waiting.
// ----------------------------------------------------------------------------
module calib_result_checker
	import sidc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  m_tlast,
	output int                    pending,
	output int                    failures
);

	typedef struct packed {
		logic [IDX_W-1:0]       sensor;
		logic [SAMPLE_BITS-1:0] idle;
		logic [SAMPLE_BITS-1:0] low;
		logic [SAMPLE_BITS-1:0] high;
		logic [DZ_W-1:0]        dead_zone;
		logic                   pos_warn;
		logic                   zone_warn;
		logic [DZ_W-1:0]        peak;
		logic                   any_warn;
		logic                   last;
	} sensor_report_t;

	// Register copies, updated by watching the write port.
	logic [ROUND_W-1:0]     iter_target;
	logic [SAMPLE_BITS-1:0] zone_limit;
	logic [SAMPLE_BITS-1:0] window_lo;
	logic [SAMPLE_BITS-1:0] window_hi;

	// Calibration state per sensor.
	logic [SUM_W-1:0]       sum_acc [MAX_SENSORS];
	logic [SAMPLE_BITS-1:0] low_seen [MAX_SENSORS];
	logic [SAMPLE_BITS-1:0] high_seen [MAX_SENSORS];
	logic [ROUND_W-1:0]     round_cnt;

	sensor_report_t report_q[$];

	function automatic string describe(sensor_report_t r);
		return $sformatf("sensor %0d idle %0d min %0d max %0d dz %0d pos %0b zone %0b %s",
			r.sensor, r.idle, r.low, r.high, r.dead_zone, r.pos_warn, r.zone_warn,
			$sformatf("peak %0d any %0b last %0b", r.peak, r.any_warn, r.last));
	endfunction

	task automatic clear_calibration();
		for (int s = 0; s < MAX_SENSORS; s++) begin
			sum_acc[s]   = '0;
			low_seen[s]  = LOW_INIT;
			high_seen[s] = '0;
		end
		round_cnt = '0;
	endtask

	// A finish round reports mean, extremes and warnings for every sensor. With
	// no rounds collected there is nothing to average and nothing is reported.
	task automatic close_calibration();
		sensor_report_t r;
		int mean;
		int low_dev;
		int high_dev;
		int dz;
		int peak_dz;
		logic warned;
		peak_dz = 0;
		warned  = 1'b0;
		if (round_cnt != 0) begin
			for (int s = 0; s < MAX_SENSORS; s++) begin
				mean     = int'(sum_acc[s] / round_cnt);
				low_dev  = mean - int'(low_seen[s]);
				high_dev = int'(high_seen[s]) - mean;
				dz       = ((low_dev > high_dev) ? low_dev : high_dev) + MARGIN;
				if (dz < 0) begin
					dz = 0;
				end
				r.sensor    = IDX_W'(s);
				r.idle      = SAMPLE_BITS'(mean);
				r.low       = low_seen[s];
				r.high      = high_seen[s];
				r.dead_zone = DZ_W'(dz);
				r.pos_warn  = (mean < int'(window_lo)) || (mean > int'(window_hi));
				r.zone_warn = dz > int'(zone_limit);
				if (dz > peak_dz) begin
					peak_dz = dz;
				end
				if (r.pos_warn || r.zone_warn) begin
					warned = 1'b1;
				end
				r.peak     = DZ_W'(peak_dz);
				r.any_warn = warned;
				r.last     = (s == MAX_SENSORS - 1);
				report_q.push_back(r);
			end
		end
		clear_calibration();
	endtask

	// One reading round: either it finishes the calibration (its samples are
	// dropped) or each present sensor accumulates its sample.
	task automatic absorb_round(logic [S_DATA_W-1:0] word);
		logic [SAMPLE_BITS-1:0] sample;
		if (round_cnt >= iter_target) begin
			close_calibration();
		end else begin
			for (int s = 0; s < MAX_SENSORS; s++) begin
				if (word[s]) begin
					sample     = word[MASK_W + s * SAMPLE_BITS +: SAMPLE_BITS];
					sum_acc[s] = sum_acc[s] + SUM_W'(sample);
					if (sample < low_seen[s]) begin
						low_seen[s] = sample;
					end
					if (sample > high_seen[s]) begin
						high_seen[s] = sample;
					end
				end
			end
			round_cnt = round_cnt + 1'b1;
		end
	endtask

	// Track writes and input transfers, then check every result transfer.
	always @(posedge clk or negedge arst_n) begin
		sensor_report_t got;
		sensor_report_t want;
		if (!arst_n) begin
			iter_target = REQ_ITER_RST;
			zone_limit  = DZ_LIMIT_RST;
			window_lo   = WIN_LO_RST;
			window_hi   = WIN_HI_RST;
			clear_calibration();
			report_q.delete();
			pending  = 0;
			failures = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_REQ_ITER: iter_target = cfg_wdata[ROUND_W-1:0];
					REG_DZ_LIMIT: zone_limit  = cfg_wdata[SAMPLE_BITS-1:0];
					REG_WIN_LO:   window_lo   = cfg_wdata[SAMPLE_BITS-1:0];
					REG_WIN_HI:   window_hi   = cfg_wdata[SAMPLE_BITS-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				absorb_round(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				got.sensor    = m_tdata[O_IDX_LSB +: IDX_W];
				got.idle      = m_tdata[O_IDLE_LSB +: SAMPLE_BITS];
				got.low       = m_tdata[O_MIN_LSB +: SAMPLE_BITS];
				got.high      = m_tdata[O_MAX_LSB +: SAMPLE_BITS];
				got.dead_zone = m_tdata[O_DZ_LSB +: DZ_W];
				got.pos_warn  = m_tdata[O_POS_BIT];
				got.zone_warn = m_tdata[O_ZONE_BIT];
				got.peak      = m_tdata[O_PEAK_LSB +: DZ_W];
				got.any_warn  = m_tdata[O_ANY_BIT];
				got.last      = m_tlast;
				if (report_q.size() == 0) begin
					failures++;
					if (failures <= 10) begin
						$display("Unexpected result transfer: %s", describe(got));
					end
				end else begin
					want = report_q.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10) begin
							$display("Result mismatch, expected %s", describe(want));
							$display("                 received %s", describe(got));
						end
					end
				end
			end
			pending = report_q.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the idle offset and dead zone calibrator. It runs directed
// rounds over the register extremes and special cases, and then random
// calibrations under three idling patterns on both streams. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import sidc_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16 * MAX_SENSORS + 32;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 480;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

	typedef enum int {
		NEAR_CENTER,
		FULL_RANGE,
		RAIL_HEAVY
	} round_style_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  m_tready  = 1'b0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;

	int pending;
	int failures;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request  = 0;
	int hold_ack      = 0;
	int hold_left     = 0;
	int items_sent    = 0;
	int unsigned cycle_count = 0;
	int center [MAX_SENSORS];

	always #6 clk = ~clk;

	sensor_idle_deadzone_calibrator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	calib_result_checker result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.pending   (pending),
		.failures  (failures)
	);

	// Result side: random back-pressure, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_ack != hold_request) begin
			hold_ack  <= hold_request;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(int iters, int limit, int lo, int hi);
		write_reg(REG_REQ_ITER, CFG_DATA_W'(iters));
		write_reg(REG_DZ_LIMIT, CFG_DATA_W'(limit));
		write_reg(REG_WIN_LO, CFG_DATA_W'(lo));
		write_reg(REG_WIN_HI, CFG_DATA_W'(hi));
	endtask

	// Offer one reading round after a random gap and wait for its transfer.
	// Valid is left high so that the next round can follow without a gap.
	task automatic offer_round(logic [S_DATA_W-1:0] word);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Stop offering and wait until every predicted result has arrived, then
	// give a finish round without results time to complete.
	task automatic await_idle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [S_DATA_W-1:0] uniform_round(logic [MASK_W-1:0] mask,
			logic [SAMPLE_BITS-1:0] value);
		logic [S_DATA_W-1:0] word;
		word = '0;
		word[MASK_W-1:0] = mask;
		for (int s = 0; s < MAX_SENSORS; s++) begin
			word[MASK_W + s * SAMPLE_BITS +: SAMPLE_BITS] = value;
		end
		return word;
	endfunction

	function automatic logic [S_DATA_W-1:0] random_round(logic [MASK_W-1:0] mask,
			round_style_t style, int spread);
		logic [S_DATA_W-1:0] word;
		int v;
		word = '0;
		word[MASK_W-1:0] = mask;
		for (int s = 0; s < MAX_SENSORS; s++) begin
			case (style)
				NEAR_CENTER: v = center[s] - spread + int'($urandom_range(0, 2 * spread));
				FULL_RANGE:  v = $urandom_range(0, SAMPLE_MAX);
				default: begin
					case ($urandom_range(0, 2))
						0:       v = 0;
						1:       v = SAMPLE_MAX;
						default: v = $urandom_range(0, SAMPLE_MAX);
					endcase
				end
			endcase
			if (v < 0) begin
				v = 0;
			end
			if (v > SAMPLE_MAX) begin
				v = SAMPLE_MAX;
			end
			word[MASK_W + s * SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(v);
		end
		return word;
	endfunction

	// One calibration: the requested rounds and the finish round. A share of
	// calibrations is plain noise of random length, so that finishes also
	// fall at other positions.
	task automatic run_calibration(int iters);
		round_style_t style;
		logic [MASK_W-1:0] mask;
		int pick;
		int spread;
		int rounds;
		pick   = $urandom_range(0, 9);
		style  = (pick < 6) ? NEAR_CENTER : (pick < 8) ? FULL_RANGE : RAIL_HEAVY;
		spread = (1 << $urandom_range(0, 8)) - 1;
		for (int s = 0; s < MAX_SENSORS; s++) begin
			center[s] = $urandom_range(0, SAMPLE_MAX);
		end
		rounds = iters + 1;
		if ($urandom_range(0, 99) < 15) begin
			style  = FULL_RANGE;
			rounds = $urandom_range(1, iters + 3);
		end
		for (int r = 0; r < rounds; r++) begin
			mask = ($urandom_range(0, 99) < 70) ? {MASK_W{1'b1}} : MASK_W'($urandom);
			offer_round(random_round(mask, style, spread));
		end
	endtask

	// Random register setting: mostly short calibrations, and a window that
	// is sometimes inverted.
	task automatic random_setup(output int iters);
		int limit;
		int lo;
		int hi;
		case ($urandom_range(0, 9))
			0:       iters = $urandom_range(20, 30);
			1, 2:    iters = $urandom_range(7, 19);
			default: iters = $urandom_range(1, 6);
		endcase
		limit = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, SAMPLE_MAX);
		if ($urandom_range(0, 9) < 8) begin
			lo = $urandom_range(0, 600);
			hi = lo + $urandom_range(0, SAMPLE_MAX - 600);
		end else begin
			lo = $urandom_range(0, SAMPLE_MAX);
			hi = $urandom_range(0, SAMPLE_MAX);
		end
		write_all(iters, limit, lo, hi);
	endtask

	initial begin
		int iters;
		int base_items;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: rail readings and a partial mask, then the
		// round count is lowered below the rounds already taken.
		offer_round(uniform_round('1, '0));
		offer_round(uniform_round('1, '1));
		offer_round(random_round(8'h55, FULL_RANGE, 0));
		await_idle();
		write_reg(REG_REQ_ITER, 16'd2);
		offer_round(uniform_round('1, '1));

		// Zero limit with an inverted window; sensors that never report, a
		// partial mask at full scale and a single sensor at midscale.
		await_idle();
		write_all(1, 0, SAMPLE_MAX, 0);
		offer_round(random_round('0, FULL_RANGE, 0));
		offer_round(random_round('1, FULL_RANGE, 0));
		offer_round(uniform_round(8'hAA, '1));
		offer_round(random_round('1, FULL_RANGE, 0));
		offer_round(uniform_round(8'h01, 10'd512));
		offer_round(random_round('1, FULL_RANGE, 0));

		// A round count of zero finishes without results; then the largest
		// count, lowered to zero in the middle of a calibration.
		await_idle();
		write_all(0, SAMPLE_MAX, 512, 512);
		offer_round(random_round('1, FULL_RANGE, 0));
		offer_round(random_round(8'h0F, FULL_RANGE, 0));
		await_idle();
		write_reg(REG_REQ_ITER, 16'hFFFF);
		repeat (3) offer_round(random_round(MASK_W'($urandom_range(0, 255)), FULL_RANGE, 0));
		await_idle();
		write_reg(REG_REQ_ITER, 16'd0);
		offer_round(random_round('1, FULL_RANGE, 0));
		offer_round(random_round('1, FULL_RANGE, 0));

		// Long hold-off on the result side while rounds keep coming, so that
		// the block fills up and stalls its input.
		await_idle();
		write_all(2, 20, 100, 900);
		hold_request <= hold_request + 1;
		repeat (4) run_calibration(2);

		// Random calibrations under three idling patterns.
		base_items = items_sent;
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct  = (mode == 0) ? 22 : (mode == 1) ? 45 : 0;
			recv_idle_pct <= (mode == 0) ? 45 : (mode == 1) ? 22 : 0;
			while (items_sent < base_items + (mode + 1) * RANDOM_ITEMS / 3) begin
				await_idle();
				random_setup(iters);
				repeat ($urandom_range(2, 5)) run_calibration(iters);
			end
		end

		await_idle();
		if (failures == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
